/* rtl/core/srec_record_parser_core_defines.svh */
// Assertion macros shared by the S-record parser RTL.
`ifndef SREC_RECORD_PARSER_CORE_DEFINES_SVH
`define SREC_RECORD_PARSER_CORE_DEFINES_SVH

// Checks a consequence in the same cycle as its antecedent.
`define SREC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks a consequence in the cycle after its antecedent.
`define SREC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/srec_pkg.sv */
// Types, codes and helper functions of the S-record parser.
`timescale 1ns / 1ps
package srec_pkg;

  localparam int CHAR_W   = 8;
  localparam int KIND_W   = 2;
  localparam int ADDR_W   = 32;
  localparam int LEN_W    = 8;
  localparam int CODE_W   = 3;
  localparam int NIBBLE_W = 4;
  localparam int ABYTES_W = 3;

  localparam logic [CHAR_W-1:0] CHAR_S  = 8'h53;
  localparam logic [CHAR_W-1:0] CHAR_0  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_1  = 8'h31;
  localparam logic [CHAR_W-1:0] CHAR_2  = 8'h32;
  localparam logic [CHAR_W-1:0] CHAR_3  = 8'h33;
  localparam logic [CHAR_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_LF = 8'h0A;

  localparam logic [ABYTES_W-1:0] ABYTES_S1  = 3'd2;
  localparam logic [ABYTES_W-1:0] ABYTES_S2  = 3'd3;
  localparam logic [ABYTES_W-1:0] ABYTES_S3  = 3'd4;
  localparam logic [ABYTES_W-1:0] ABYTES_HDR = 3'd2;

  localparam logic [KIND_W-1:0] KIND_DATA   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RECORD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STOP   = 2'd2;

  localparam logic [CODE_W-1:0] STOP_TYPE   = 3'd0;
  localparam logic [CODE_W-1:0] STOP_CSUM   = 3'd1;
  localparam logic [CODE_W-1:0] STOP_CRLF   = 3'd2;
  localparam logic [CODE_W-1:0] STOP_HEADER = 3'd3;
  localparam logic [CODE_W-1:0] STOP_COUNT  = 3'd4;

  typedef enum logic [9:0] {
    PH_HDR_S    = 10'b00_0000_0001,
    PH_HDR_TYPE = 10'b00_0000_0010,
    PH_REC_S    = 10'b00_0000_0100,
    PH_REC_TYPE = 10'b00_0000_1000,
    PH_COUNT    = 10'b00_0001_0000,
    PH_ADDR     = 10'b00_0010_0000,
    PH_DATA     = 10'b00_0100_0000,
    PH_CSUM     = 10'b00_1000_0000,
    PH_CR       = 10'b01_0000_0000,
    PH_LF       = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] address;
    logic [CHAR_W-1:0] data_byte;
    logic [LEN_W-1:0]  record_length;
    logic [CODE_W-1:0] stop_code;
  } result_t;

  // A character that is not a hex digit counts as zero.
  function automatic logic [NIBBLE_W-1:0] hex_val(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    d = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
    end
    return d[NIBBLE_W-1:0];
  endfunction

endpackage

/* rtl/core/srec_char_if.sv */
// Character stream channel: one image character per beat.
`timescale 1ns / 1ps
interface srec_char_if;
  logic                          valid;
  logic                          ready;
  logic [srec_pkg::CHAR_W-1:0]   in_char;

  modport source (output valid, output in_char, input ready);
  modport sink (input valid, input in_char, output ready);
endinterface

/* rtl/core/srec_result_if.sv */
// Result stream channel: one data byte, record completion or stop per beat.
`timescale 1ns / 1ps
interface srec_result_if;
  logic                          valid;
  logic                          ready;
  logic [srec_pkg::KIND_W-1:0]   kind;
  logic [srec_pkg::ADDR_W-1:0]   address;
  logic [srec_pkg::CHAR_W-1:0]   data_byte;
  logic [srec_pkg::LEN_W-1:0]    record_length;
  logic [srec_pkg::CODE_W-1:0]   stop_code;

  modport source (output valid, output kind, output address, output data_byte,
                  output record_length, output stop_code, input ready);
  modport sink (input valid, input kind, input address, input data_byte,
                input record_length, input stop_code, output ready);
endinterface

/* rtl/core/srec_record_parser_core.sv */
// S-record parser core: turns an image character stream into data and status beats.
//
// The chars channel takes one ASCII character of a Motorola S-record image per
// beat. The results channel gives data byte beats (kind 0) with their target
// address, a record-complete beat (kind 1) after the CR LF of each valid data
// record, and one stop beat (kind 2) on the first error. Data bytes leave
// before their checksum is checked, so a record that ends in a stop must be
// discarded by the consumer. After a stop, characters are still taken but
// ignored until reset.
//
// A character lands in an input register, is decoded by combinational logic
// against the parser state and its result lands in the output register. With
// the results channel ready the core takes one character every cycle. When the
// receiver stalls, the pending result holds and an empty input register still
// fills, so at most one more character is taken before chars.ready drops.
//
// Synchronous reset returns the parser to expecting the S of an S0 header and
// empties both registers; no clearing pass is needed.
`timescale 1ns / 1ps
`include "srec_record_parser_core_defines.svh"
module srec_record_parser_core (
  input  logic              clk,
  input  logic              rst,
  srec_char_if.sink         chars,
  srec_result_if.source     results
);
  import srec_pkg::*;

  logic                  in_vld;
  logic [CHAR_W-1:0]     in_char_q;
  logic                  out_vld;
  result_t               res_q;
  logic                  advance;

  phase_t                phase, phase_next;
  logic [NIBBLE_W-1:0]   high_nibble, high_nibble_next;
  logic                  nibble_pending, nibble_pending_next;
  logic [ABYTES_W-1:0]   address_bytes, address_bytes_next;
  logic [LEN_W-1:0]      bytes_left, bytes_left_next;
  logic [CHAR_W-1:0]     running_sum, running_sum_next;
  logic [ADDR_W-1:0]     base_address, base_address_next;
  logic [LEN_W-1:0]      byte_offset, byte_offset_next;
  logic                  is_header, is_header_next;
  logic                  stopped, stopped_next;

  logic                  res_vld;
  result_t               res;
  logic [NIBBLE_W-1:0]   nib;
  logic [CHAR_W-1:0]     bval;
  logic [LEN_W-1:0]      bl_dec;
  logic [ABYTES_W-1:0]   ab_dec;

  assign advance     = in_vld && (!out_vld || results.ready);
  assign chars.ready = !in_vld || advance;

  assign nib    = hex_val(in_char_q);
  assign bval   = {high_nibble, nib};
  assign bl_dec = bytes_left - 8'd1;
  assign ab_dec = address_bytes - 3'd1;

  always_comb begin
    phase_next          = phase;
    high_nibble_next    = high_nibble;
    nibble_pending_next = nibble_pending;
    address_bytes_next  = address_bytes;
    bytes_left_next     = bytes_left;
    running_sum_next    = running_sum;
    base_address_next   = base_address;
    byte_offset_next    = byte_offset;
    is_header_next      = is_header;
    stopped_next        = stopped;
    res_vld             = 1'b0;
    res                 = '0;

    if (!stopped) begin
      unique case (phase)
        PH_HDR_S: begin
          if (in_char_q != CHAR_S) begin
            res_vld = 1'b1;
            res.stop_code = STOP_HEADER;
          end else begin
            phase_next = PH_HDR_TYPE;
          end
        end
        PH_HDR_TYPE: begin
          if (in_char_q != CHAR_0) begin
            res_vld = 1'b1;
            res.stop_code = STOP_HEADER;
          end else begin
            address_bytes_next  = ABYTES_HDR;
            nibble_pending_next = 1'b0;
            phase_next          = PH_COUNT;
          end
        end
        PH_REC_S: begin
          if (in_char_q != CHAR_S) begin
            res_vld = 1'b1;
            res.stop_code = STOP_TYPE;
          end else begin
            phase_next = PH_REC_TYPE;
          end
        end
        PH_REC_TYPE: begin
          nibble_pending_next = 1'b0;
          phase_next          = PH_COUNT;
          if (in_char_q == CHAR_1) begin
            address_bytes_next = ABYTES_S1;
          end else if (in_char_q == CHAR_2) begin
            address_bytes_next = ABYTES_S2;
          end else if (in_char_q == CHAR_3) begin
            address_bytes_next = ABYTES_S3;
          end else begin
            nibble_pending_next = nibble_pending;
            phase_next          = phase;
            res_vld             = 1'b1;
            res.stop_code       = STOP_TYPE;
          end
        end
        PH_CR: begin
          if (in_char_q != CHAR_CR) begin
            res_vld = 1'b1;
            res.stop_code = STOP_CRLF;
          end else begin
            phase_next = PH_LF;
          end
        end
        PH_LF: begin
          if (in_char_q != CHAR_LF) begin
            res_vld = 1'b1;
            res.stop_code = STOP_CRLF;
          end else begin
            phase_next     = PH_REC_S;
            is_header_next = 1'b0;
            if (!is_header) begin
              res_vld           = 1'b1;
              res.kind          = KIND_RECORD;
              res.address       = base_address;
              res.record_length = byte_offset;
            end
          end
        end
        PH_COUNT, PH_ADDR, PH_DATA, PH_CSUM: begin
          if (!nibble_pending) begin
            high_nibble_next    = nib;
            nibble_pending_next = 1'b1;
          end else begin
            nibble_pending_next = 1'b0;
            if (phase == PH_COUNT) begin
              running_sum_next = bval;
              bytes_left_next  = bval;
              if ({1'b0, bval} < ({6'd0, address_bytes} + 9'd1)) begin
                res_vld = 1'b1;
                res.stop_code = STOP_COUNT;
              end else begin
                base_address_next = '0;
                byte_offset_next  = '0;
                phase_next        = PH_ADDR;
              end
            end else if (phase == PH_ADDR) begin
              running_sum_next   = running_sum + bval;
              base_address_next  = {base_address[ADDR_W-CHAR_W-1:0], bval};
              bytes_left_next    = bl_dec;
              address_bytes_next = ab_dec;
              if (ab_dec == 3'd0) begin
                phase_next = (bl_dec <= 8'd1) ? PH_CSUM : PH_DATA;
              end
            end else if (phase == PH_DATA) begin
              running_sum_next = running_sum + bval;
              bytes_left_next  = bl_dec;
              byte_offset_next = byte_offset + 8'd1;
              phase_next       = (bl_dec <= 8'd1) ? PH_CSUM : PH_DATA;
              if (!is_header) begin
                res_vld       = 1'b1;
                res.kind      = KIND_DATA;
                res.address   = base_address + {24'd0, byte_offset};
                res.data_byte = bval;
              end
            end else begin
              if (~running_sum != bval) begin
                res_vld = 1'b1;
                res.stop_code = STOP_CSUM;
              end else if (is_header && base_address != '0) begin
                res_vld = 1'b1;
                res.stop_code = STOP_HEADER;
              end else begin
                phase_next = PH_CR;
              end
            end
          end
        end
        default: begin
          res_vld = 1'b1;
          res.stop_code = STOP_TYPE;
        end
      endcase
      if (res_vld && res.kind == KIND_DATA && res.stop_code == STOP_TYPE
          && phase != PH_DATA) begin
        res.kind = KIND_STOP;
      end
      if (res_vld && res.stop_code != STOP_TYPE) begin
        res.kind = KIND_STOP;
      end
      if (res_vld && res.kind == KIND_STOP) begin
        stopped_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld         <= 1'b0;
      out_vld        <= 1'b0;
      phase          <= PH_HDR_S;
      high_nibble    <= '0;
      nibble_pending <= 1'b0;
      address_bytes  <= '0;
      bytes_left     <= '0;
      running_sum    <= '0;
      base_address   <= '0;
      byte_offset    <= '0;
      is_header      <= 1'b1;
      stopped        <= 1'b0;
    end else begin
      if (chars.valid && chars.ready) begin
        in_vld <= 1'b1;
      end else if (advance) begin
        in_vld <= 1'b0;
      end
      if (advance) begin
        out_vld        <= res_vld;
        phase          <= phase_next;
        high_nibble    <= high_nibble_next;
        nibble_pending <= nibble_pending_next;
        address_bytes  <= address_bytes_next;
        bytes_left     <= bytes_left_next;
        running_sum    <= running_sum_next;
        base_address   <= base_address_next;
        byte_offset    <= byte_offset_next;
        is_header      <= is_header_next;
        stopped        <= stopped_next;
      end else if (results.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      in_char_q <= chars.in_char;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign results.valid         = out_vld;
  assign results.kind          = res_q.kind;
  assign results.address       = res_q.address;
  assign results.data_byte     = res_q.data_byte;
  assign results.record_length = res_q.record_length;
  assign results.stop_code     = res_q.stop_code;

  `SREC_ASSERT_NEXT(a_stop_sticky, clk, rst, stopped, stopped,
                    "stop flag cleared without reset")
  `SREC_ASSERT_SAME(a_stop_beat_flag, clk, rst, out_vld && res_q.kind == KIND_STOP,
                    stopped, "stop beat without stop flag")
  `SREC_ASSERT_SAME(a_code_only_on_stop, clk, rst, out_vld && res_q.kind != KIND_STOP,
                    res_q.stop_code == STOP_TYPE, "stop code on a non-stop beat")
  `SREC_ASSERT_NEXT(a_no_beat_after_stop, clk, rst, stopped && (!out_vld || results.ready),
                    !out_vld, "beat produced after stop")

endmodule

/* verif/srec_record_parser_core_tb.sv */
// Self-checking testbench for the S-record parser core: generated images against a predictor.
`timescale 1ns / 1ps
module srec_record_parser_core_tb;
  import srec_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD   = 150;
  localparam int TAIL_CYCLES = 20;

  typedef enum int {
    FAULT_NONE,
    FAULT_NOT_S,
    FAULT_TYPE,
    FAULT_COUNT,
    FAULT_CSUM,
    FAULT_CR,
    FAULT_LF
  } fault_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              hold;
  } feed_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  srec_char_if   chars_if ();
  srec_result_if results_if ();

  srec_record_parser_core u_top (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .results (results_if)
  );

  feed_t   image_q[$];
  result_t decoded_q[$];
  logic    pause_next     = 1'b0;
  logic    char_beat      = 1'b0;
  logic    long_hold_done = 1'b0;
  int      chars_taken    = 0;
  int      mismatches     = 0;
  int      cycles         = 0;
  int      gap_left       = 0;
  int      src_calm       = 0;
  int      hold_left      = 0;
  int      sink_calm      = 0;

  phase_t              ph         = PH_HDR_S;
  logic [NIBBLE_W-1:0] hi_nib     = '0;
  logic                nib_pend   = 1'b0;
  logic [ABYTES_W-1:0] addr_left  = '0;
  logic [LEN_W-1:0]    bytes_left = '0;
  logic [CHAR_W-1:0]   run_sum    = '0;
  logic [ADDR_W-1:0]   base_addr  = '0;
  logic [LEN_W-1:0]    offs       = '0;
  logic                in_hdr     = 1'b1;
  logic                halted     = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [NIBBLE_W-1:0] nibble_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] v;
    v = '0;
    if (c >= "0" && c <= "9") begin
      v = c - "0";
    end else if (c >= "A" && c <= "F") begin
      v = c - "A" + 8'd10;
    end else if (c >= "a" && c <= "f") begin
      v = c - "a" + 8'd10;
    end
    return v[NIBBLE_W-1:0];
  endfunction

  function automatic void push_result(input logic [KIND_W-1:0] k, input logic [ADDR_W-1:0] a,
                                      input logic [CHAR_W-1:0] db, input logic [LEN_W-1:0] len,
                                      input logic [CODE_W-1:0] code);
    result_t r;
    r.kind          = k;
    r.address       = a;
    r.data_byte     = db;
    r.record_length = len;
    r.stop_code     = code;
    decoded_q.push_back(r);
  endfunction

  function automatic void halt_with(input logic [CODE_W-1:0] code);
    halted = 1'b1;
    push_result(KIND_STOP, '0, '0, '0, code);
  endfunction

  // Advances the parser state by one character and queues the beat it causes.
  function automatic void parse_char(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] b;
    if (halted) return;
    case (ph)
      PH_HDR_S: begin
        if (c != CHAR_S) halt_with(STOP_HEADER);
        else ph = PH_HDR_TYPE;
      end
      PH_HDR_TYPE: begin
        if (c != CHAR_0) begin
          halt_with(STOP_HEADER);
        end else begin
          addr_left = ABYTES_HDR;
          nib_pend  = 1'b0;
          ph        = PH_COUNT;
        end
      end
      PH_REC_S: begin
        if (c != CHAR_S) halt_with(STOP_TYPE);
        else ph = PH_REC_TYPE;
      end
      PH_REC_TYPE: begin
        if (c == CHAR_1) begin
          addr_left = ABYTES_S1;
        end else if (c == CHAR_2) begin
          addr_left = ABYTES_S2;
        end else if (c == CHAR_3) begin
          addr_left = ABYTES_S3;
        end else begin
          halt_with(STOP_TYPE);
          return;
        end
        nib_pend = 1'b0;
        ph       = PH_COUNT;
      end
      PH_CR: begin
        if (c != CHAR_CR) halt_with(STOP_CRLF);
        else ph = PH_LF;
      end
      PH_LF: begin
        if (c != CHAR_LF) begin
          halt_with(STOP_CRLF);
        end else begin
          ph = PH_REC_S;
          if (in_hdr) in_hdr = 1'b0;
          else push_result(KIND_RECORD, base_addr, '0, offs, '0);
        end
      end
      default: begin
        if (!nib_pend) begin
          hi_nib   = nibble_of(c);
          nib_pend = 1'b1;
        end else begin
          nib_pend = 1'b0;
          b = {hi_nib, nibble_of(c)};
          case (ph)
            PH_COUNT: begin
              run_sum    = b;
              bytes_left = b;
              if (b < addr_left + 8'd1) begin
                halt_with(STOP_COUNT);
              end else begin
                base_addr = '0;
                offs      = '0;
                ph        = PH_ADDR;
              end
            end
            PH_ADDR: begin
              run_sum    = run_sum + b;
              base_addr  = {base_addr[ADDR_W-9:0], b};
              bytes_left = bytes_left - 8'd1;
              addr_left  = addr_left - 3'd1;
              if (addr_left == '0) begin
                if (bytes_left <= 8'd1) ph = PH_CSUM;
                else ph = PH_DATA;
              end
            end
            PH_DATA: begin
              if (!in_hdr) push_result(KIND_DATA, base_addr + offs, b, '0, '0);
              run_sum    = run_sum + b;
              bytes_left = bytes_left - 8'd1;
              offs       = offs + 8'd1;
              if (bytes_left <= 8'd1) ph = PH_CSUM;
              else ph = PH_DATA;
            end
            default: begin
              if (b != ~run_sum) halt_with(STOP_CSUM);
              else if (in_hdr && base_addr != '0) halt_with(STOP_HEADER);
              else ph = PH_CR;
            end
          endcase
        end
      end
    endcase
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CHAR_W-1:0] any_char_except(input logic [CHAR_W-1:0] lo,
                                                        input logic [CHAR_W-1:0] hi);
    logic [CHAR_W-1:0] c;
    c = $urandom_range(0, 255);
    while (c >= lo && c <= hi) c = $urandom_range(0, 255);
    return c;
  endfunction

  task automatic put_char(input logic [CHAR_W-1:0] c);
    feed_t f;
    f.ch   = c;
    f.hold = pause_next;
    pause_next = 1'b0;
    image_q.push_back(f);
  endtask

  // A zero nibble is sometimes sent as a character that is not a hex digit.
  task automatic put_nibble(input logic [NIBBLE_W-1:0] n);
    logic [CHAR_W-1:0] c;
    if (n == '0 && $urandom_range(0, 9) == 0) begin
      c = $urandom_range(0, 255);
      while ((c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f"))
        c = $urandom_range(0, 255);
    end else if (n < 4'd10) begin
      c = CHAR_0 + n;
    end else if ($urandom_range(0, 1) == 1) begin
      c = "A" + n - 8'd10;
    end else begin
      c = "a" + n - 8'd10;
    end
    put_char(c);
  endtask

  task automatic put_byte(input logic [CHAR_W-1:0] b);
    put_nibble(b[7:4]);
    put_nibble(b[3:0]);
  endtask

  task automatic put_record(input logic [CHAR_W-1:0] type_char, input int naddr,
                            input logic [ADDR_W-1:0] addr, input int len, input fault_t fault);
    logic [CHAR_W-1:0] cnt;
    logic [CHAR_W-1:0] sum;
    logic [CHAR_W-1:0] b;
    int r;
    cnt = naddr + len + 1;
    if (fault == FAULT_COUNT) cnt = $urandom_range(0, naddr);
    put_char(fault == FAULT_NOT_S ? any_char_except(CHAR_S, CHAR_S) : CHAR_S);
    if (fault != FAULT_TYPE) put_char(type_char);
    else if ($urandom_range(0, 1) == 1) put_char(CHAR_0 + $urandom_range(4, 9));
    else put_char(any_char_except(CHAR_1, CHAR_3));
    put_byte(cnt);
    sum = cnt;
    for (int i = naddr - 1; i >= 0; i--) begin
      b = addr[8*i +: 8];
      put_byte(b);
      sum = sum + b;
    end
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 15);
      if (r == 0) b = 8'h00;
      else if (r == 1) b = 8'hFF;
      else b = $urandom_range(0, 255);
      put_byte(b);
      sum = sum + b;
    end
    b = ~sum;
    if (fault == FAULT_CSUM) b = b ^ $urandom_range(1, 255);
    put_byte(b);
    put_char(fault == FAULT_CR ? any_char_except(CHAR_CR, CHAR_CR) : CHAR_CR);
    put_char(fault == FAULT_LF ? any_char_except(CHAR_LF, CHAR_LF) : CHAR_LF);
  endtask

  task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
                             input logic [ADDR_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(negedge clk) begin
    if (char_beat) begin
      image_q.delete(0);
      if (src_calm != 0) src_calm--;
      else if ($urandom_range(0, 59) == 0) src_calm = $urandom_range(20, 80);
      else if ($urandom_range(0, 2) == 0) gap_left = idle_len();
    end
    if (rst) begin
      chars_if.valid <= 1'b0;
    end else if (gap_left != 0) begin
      chars_if.valid <= 1'b0;
      gap_left--;
    end else if (image_q.size() == 0) begin
      chars_if.valid <= 1'b0;
    end else if (image_q[0].hold && decoded_q.size() != 0) begin
      chars_if.valid <= 1'b0;
    end else begin
      chars_if.valid   <= 1'b1;
      chars_if.in_char <= image_q[0].ch;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
    end else if (!long_hold_done && chars_taken >= 300) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD;
      results_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      results_if.ready <= 1'b0;
    end else begin
      if (sink_calm != 0) sink_calm--;
      else if ($urandom_range(0, 49) == 0) sink_calm = $urandom_range(30, 100);
      if (sink_calm == 0 && $urandom_range(0, 3) == 0) hold_left = idle_len() - 1;
      results_if.ready <= (sink_calm != 0 || hold_left == 0 && $urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin : monitor
    result_t want;
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      char_beat = 1'b0;
      if (!rst) begin
        if (chars_if.valid && chars_if.ready) begin
          char_beat = 1'b1;
          chars_taken++;
          parse_char(chars_if.in_char);
        end
        if (results_if.valid && results_if.ready) begin
          if (decoded_q.size() == 0) begin
            $error("result beat with nothing expected: kind %0d address %0h",
                   results_if.kind, results_if.address);
            mismatches++;
          end else begin
            want = decoded_q.pop_front();
            check_field("kind", want.kind, results_if.kind);
            check_field("address", want.address, results_if.address);
            check_field("data_byte", want.data_byte, results_if.data_byte);
            check_field("record_length", want.record_length, results_if.record_length);
            check_field("stop_code", want.stop_code, results_if.stop_code);
          end
        end
      end
    end
  end

  initial begin : stimulus
    int     naddr;
    int     len;
    int     target;
    int     r;
    logic   paused_once;
    logic [ADDR_W-1:0] addr;
    fault_t tail_fault;

    chars_if.valid   = 1'b0;
    chars_if.in_char = '0;
    results_if.ready = 1'b0;
    paused_once      = 1'b0;

    // The header text is never emitted; the records after it cover the address extremes,
    // an empty record, a wrap past the top of the address space and the longest record.
    put_record(CHAR_0, 2, 32'h0, 4, FAULT_NONE);
    put_record(CHAR_1, 2, 32'h0000_1234, 0, FAULT_NONE);
    put_record(CHAR_1, 2, 32'h0000_FFFF, 1, FAULT_NONE);
    put_record(CHAR_2, 3, 32'h00FF_FFFF, 2, FAULT_NONE);
    put_record(CHAR_3, 4, 32'hFFFF_FFFE, 4, FAULT_NONE);
    put_record(CHAR_3, 4, 32'h0, 1, FAULT_NONE);
    put_record(CHAR_1, 2, $urandom, 252, FAULT_NONE);

    target = 950;
    while (image_q.size() < target) begin
      if (!paused_once && image_q.size() > target - 450) begin
        pause_next  = 1'b1;
        paused_once = 1'b1;
      end
      naddr = $urandom_range(2, 4);
      r = $urandom_range(0, 9);
      if (r == 0) addr = '1;
      else if (r == 1) addr = '0;
      else addr = $urandom;
      r = $urandom_range(0, 99);
      if (r < 80) len = $urandom_range(0, 8);
      else if (r < 98) len = $urandom_range(9, 40);
      else len = $urandom_range(100, 254 - naddr);
      put_record(CHAR_1 + naddr - 2, naddr, addr, len, FAULT_NONE);
    end

    // The image ends in a record with one randomly chosen error or with none; after an error, input is ignored.
    tail_fault = fault_t'($urandom_range(0, 6));
    naddr = $urandom_range(2, 4);
    put_record(CHAR_1 + naddr - 2, naddr, $urandom, $urandom_range(0, 4), tail_fault);
    if (tail_fault != FAULT_NONE) repeat (20) put_char($urandom_range(0, 255));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (image_q.size() != 0 || decoded_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/srec_pkg.sv
rtl/core/srec_char_if.sv
rtl/core/srec_result_if.sv
rtl/core/srec_record_parser_core.sv
verif/srec_record_parser_core_tb.sv
